// ----- rtl/core/psfp_pkg.sv -----
// ============================================================================
// psfp_pkg - shared types and constants for the printf spec field parser
// Holds the parse phase type, field codes and the saturating decimal
// accumulate used for width and precision digits.
// ============================================================================
package psfp_pkg;

    // Saturation limit of decimal digit values is 2^VALUE_BITS - 1
    localparam int unsigned VALUE_BITS = 31;
    localparam int unsigned ACC_BITS   = 35;
    localparam logic [ACC_BITS-1:0] VALUE_MAX =
        (ACC_BITS'(1) << VALUE_BITS) - ACC_BITS'(1);

    // Parse phase
    typedef enum logic [2:0] {
        PH_FLAGS   = 3'd0,
        PH_WDIG    = 3'd1,
        PH_AFTER_W = 3'd2,
        PH_PSTART  = 3'd3,
        PH_PDIG    = 3'd4,
        PH_LEN1    = 3'd5,
        PH_LEN2    = 3'd6,
        PH_TYPE    = 3'd7
    } phase_t;

    // Length modifier codes
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_H     = 3'd1;
    localparam logic [2:0] LEN_L     = 3'd2;
    localparam logic [2:0] LEN_HH    = 3'd3;
    localparam logic [2:0] LEN_LL    = 3'd4;
    localparam logic [2:0] LEN_MIXED = 3'd5;

    // Flag bit positions
    localparam int unsigned FLAG_LEFT  = 0;
    localparam int unsigned FLAG_ZERO  = 1;
    localparam int unsigned FLAG_PLUS  = 2;
    localparam int unsigned FLAG_SPACE = 3;
    localparam int unsigned FLAG_ALT   = 4;

    // Type codes, index in c s p d i o u x X %
    localparam logic [3:0] TYPE_C   = 4'd0;
    localparam logic [3:0] TYPE_S   = 4'd1;
    localparam logic [3:0] TYPE_P   = 4'd2;
    localparam logic [3:0] TYPE_D   = 4'd3;
    localparam logic [3:0] TYPE_I   = 4'd4;
    localparam logic [3:0] TYPE_O   = 4'd5;
    localparam logic [3:0] TYPE_U   = 4'd6;
    localparam logic [3:0] TYPE_X   = 4'd7;
    localparam logic [3:0] TYPE_XU  = 4'd8;
    localparam logic [3:0] TYPE_PCT = 4'd9;

    // acc * 10 + d, clamped to VALUE_MAX
    function automatic logic [30:0] accumulate(input logic [30:0] acc, input logic [3:0] d);
        logic [ACC_BITS-1:0] wide;
        logic [ACC_BITS-1:0] sum;
        wide = ACC_BITS'(acc);
        sum  = (wide << 3) + (wide << 1) + ACC_BITS'(d);
        if (sum > VALUE_MAX)
        begin
            sum = VALUE_MAX;
        end
        return sum[30:0];
    endfunction

endpackage

// ----- rtl/core/printf_spec_field_parser_core.sv -----
// ============================================================================
// printf_spec_field_parser_core - printf conversion spec field parser
// Parses flags, width, precision, length and type of one conversion spec,
// one character per word, and reports the fields after every character.
// ============================================================================
// One character enters per cycle while m_tready is high; every input word
// gives exactly one output word, which leaves through the output register.
// The character is held in an input register, decoded together with the
// parse state by a single pass of logic (one multiply-by-ten accumulate and
// a small character decode) and written to the output register, which also
// updates the state; full throughput holds as long as m_tready is high.
// Set the tuser bit with the first character after the percent sign to start
// a fresh spec; a word flagged with tlast ends the spec and clears the state.
module printf_spec_field_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // ch[7:0], star_arg[39:8]
    input  logic        s_tuser,   // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // consumed[0], spec_valid[1], flag_bits[6:2],
                                   // width[37:7], precision[69:38],
                                   // precision_given[70], length_code[73:71],
                                   // type_code[77:74], zero pad[79:78]
    output logic        m_tlast    // spec_done
);

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic [31:0] in_star_reg;
    logic        in_start_reg;

    // Parse state
    psfp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  flag_reg, flag_next;
    logic [30:0] width_reg, width_next;
    logic [31:0] prec_reg, prec_next;
    logic        prec_given_reg, prec_given_next;
    logic [2:0]  length_reg, length_next;

    // Result register
    logic        out_valid_reg;
    logic        out_cons_reg, out_cons_next;
    logic        out_done_reg, out_done_next;
    logic        out_ok_reg, out_ok_next;
    logic [3:0]  out_type_reg, out_type_next;

    logic        advance;

    // Move the held word to the output when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Capture input words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg    <= s_tdata[7:0];
            in_star_reg  <= s_tdata[39:8];
            in_start_reg <= s_tuser;
        end
    end

    // Decode one character against the current phase
    always_comb
    begin
        psfp_pkg::phase_t p;
        psfp_pkg::phase_t p_base;
        logic [4:0]  f;
        logic [30:0] w;
        logic [31:0] pr;
        logic        pg;
        logic [2:0]  ln;
        logic        cons;
        logic        done;
        logic        ok;
        logic [3:0]  tcode;
        logic        is_dig;
        logic [30:0] acc_src;
        logic [30:0] acc_val;
        logic [31:0] mag;
        logic [4:0]  fbit;
        logic [2:0]  lv;
        logic        t_hit;
        logic [3:0]  t_idx;

        // Start of a spec clears state first
        if (in_start_reg)
        begin
            p_base = psfp_pkg::PH_FLAGS;
            f      = '0;
            w      = '0;
            pr     = '0;
            pg     = 1'b0;
            ln     = psfp_pkg::LEN_NONE;
        end
        else
        begin
            p_base = phase_reg;
            f      = flag_reg;
            w      = width_reg;
            pr     = prec_reg;
            pg     = prec_given_reg;
            ln     = length_reg;
        end
        p     = p_base;
        cons  = 1'b0;
        done  = 1'b0;
        ok    = 1'b0;
        tcode = psfp_pkg::TYPE_C;

        // Character classes
        is_dig = (in_ch_reg >= 8'h30) && (in_ch_reg <= 8'h39);

        fbit = '0;
        unique case (in_ch_reg)
            8'h2D:   fbit[psfp_pkg::FLAG_LEFT]  = 1'b1;
            8'h30:   fbit[psfp_pkg::FLAG_ZERO]  = 1'b1;
            8'h2B:   fbit[psfp_pkg::FLAG_PLUS]  = 1'b1;
            8'h20:   fbit[psfp_pkg::FLAG_SPACE] = 1'b1;
            8'h23:   fbit[psfp_pkg::FLAG_ALT]   = 1'b1;
            default: fbit = '0;
        endcase

        unique case (in_ch_reg)
            8'h68:   lv = psfp_pkg::LEN_H;
            8'h6C:   lv = psfp_pkg::LEN_L;
            default: lv = psfp_pkg::LEN_NONE;
        endcase

        t_hit = 1'b1;
        unique case (in_ch_reg)
            8'h63:   t_idx = psfp_pkg::TYPE_C;
            8'h73:   t_idx = psfp_pkg::TYPE_S;
            8'h70:   t_idx = psfp_pkg::TYPE_P;
            8'h64:   t_idx = psfp_pkg::TYPE_D;
            8'h69:   t_idx = psfp_pkg::TYPE_I;
            8'h6F:   t_idx = psfp_pkg::TYPE_O;
            8'h75:   t_idx = psfp_pkg::TYPE_U;
            8'h78:   t_idx = psfp_pkg::TYPE_X;
            8'h58:   t_idx = psfp_pkg::TYPE_XU;
            8'h25:   t_idx = psfp_pkg::TYPE_PCT;
            default:
            begin
                t_hit = 1'b0;
                t_idx = psfp_pkg::TYPE_C;
            end
        endcase

        // One shared accumulator: only digit phases carry a running value
        if (p_base == psfp_pkg::PH_WDIG)
        begin
            acc_src = w;
        end
        else if (p_base == psfp_pkg::PH_PDIG)
        begin
            acc_src = pr[30:0];
        end
        else
        begin
            acc_src = '0;
        end
        acc_val = psfp_pkg::accumulate(acc_src, in_ch_reg[3:0]);

        // Star width magnitude, clamped
        mag = in_star_reg[31] ? (32'd0 - in_star_reg) : in_star_reg;
        if (mag > psfp_pkg::VALUE_MAX[31:0])
        begin
            mag = psfp_pkg::VALUE_MAX[31:0];
        end

        // Flags
        if (p == psfp_pkg::PH_FLAGS)
        begin
            if (fbit != '0)
            begin
                f    = f | fbit;
                cons = 1'b1;
            end
            else if (in_ch_reg == 8'h2A)
            begin
                if (in_star_reg[31])
                begin
                    f[psfp_pkg::FLAG_LEFT] = 1'b1;
                end
                w    = mag[30:0];
                p    = psfp_pkg::PH_AFTER_W;
                cons = 1'b1;
            end
            else if (is_dig)
            begin
                w    = acc_val;
                p    = psfp_pkg::PH_WDIG;
                cons = 1'b1;
            end
            else
            begin
                p = psfp_pkg::PH_AFTER_W;
            end
        end

        // Width digits
        if (!cons && p == psfp_pkg::PH_WDIG)
        begin
            if (is_dig)
            begin
                w    = acc_val;
                cons = 1'b1;
            end
            else
            begin
                p = psfp_pkg::PH_AFTER_W;
            end
        end

        // Precision dot
        if (!cons && p == psfp_pkg::PH_AFTER_W)
        begin
            if (in_ch_reg == 8'h2E)
            begin
                pg   = 1'b1;
                pr   = '0;
                p    = psfp_pkg::PH_PSTART;
                cons = 1'b1;
            end
            else
            begin
                p = psfp_pkg::PH_LEN1;
            end
        end

        // First precision character
        if (!cons && p == psfp_pkg::PH_PSTART)
        begin
            if (in_ch_reg == 8'h2A)
            begin
                pr   = in_star_reg;
                p    = psfp_pkg::PH_LEN1;
                cons = 1'b1;
            end
            else if (is_dig)
            begin
                pr   = {1'b0, acc_val};
                p    = psfp_pkg::PH_PDIG;
                cons = 1'b1;
            end
            else
            begin
                pr = '0;
                p  = psfp_pkg::PH_LEN1;
            end
        end

        // Precision digits
        if (!cons && p == psfp_pkg::PH_PDIG)
        begin
            if (is_dig)
            begin
                pr   = {1'b0, acc_val};
                cons = 1'b1;
            end
            else
            begin
                p = psfp_pkg::PH_LEN1;
            end
        end

        // First length modifier
        if (!cons && p == psfp_pkg::PH_LEN1)
        begin
            if (lv != psfp_pkg::LEN_NONE)
            begin
                ln   = lv;
                p    = psfp_pkg::PH_LEN2;
                cons = 1'b1;
            end
            else
            begin
                p = psfp_pkg::PH_TYPE;
            end
        end

        // Second length modifier
        if (!cons && p == psfp_pkg::PH_LEN2)
        begin
            if (lv != psfp_pkg::LEN_NONE)
            begin
                if (ln == psfp_pkg::LEN_H && lv == psfp_pkg::LEN_H)
                begin
                    ln = psfp_pkg::LEN_HH;
                end
                else if (ln == psfp_pkg::LEN_L && lv == psfp_pkg::LEN_L)
                begin
                    ln = psfp_pkg::LEN_LL;
                end
                else
                begin
                    ln = psfp_pkg::LEN_MIXED;
                end
                cons = 1'b1;
            end
            p = psfp_pkg::PH_TYPE;
        end

        // Type character ends the spec either way
        if (!cons && p == psfp_pkg::PH_TYPE)
        begin
            done = 1'b1;
            if (t_hit)
            begin
                ok    = 1'b1;
                cons  = 1'b1;
                tcode = t_idx;
            end
        end

        // Report fields as they stand after this character
        out_cons_next = cons;
        out_done_next = done;
        out_ok_next   = ok;
        out_type_next = tcode;
        flag_next       = f;
        width_next      = w;
        prec_next       = pr;
        prec_given_next = pg;
        length_next     = ln;
        phase_next      = p;
    end

    // Update parse state, clearing it once a spec ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= psfp_pkg::PH_FLAGS;
            flag_reg       <= '0;
            width_reg      <= '0;
            prec_reg       <= '0;
            prec_given_reg <= 1'b0;
            length_reg     <= psfp_pkg::LEN_NONE;
        end
        else if (advance)
        begin
            if (out_done_next)
            begin
                phase_reg      <= psfp_pkg::PH_FLAGS;
                flag_reg       <= '0;
                width_reg      <= '0;
                prec_reg       <= '0;
                prec_given_reg <= 1'b0;
                length_reg     <= psfp_pkg::LEN_NONE;
            end
            else
            begin
                phase_reg      <= phase_next;
                flag_reg       <= flag_next;
                width_reg      <= width_next;
                prec_reg       <= prec_next;
                prec_given_reg <= prec_given_next;
                length_reg     <= length_next;
            end
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    logic [4:0]  out_flag_reg;
    logic [30:0] out_width_reg;
    logic [31:0] out_prec_reg;
    logic        out_pg_reg;
    logic [2:0]  out_len_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_cons_reg  <= out_cons_next;
            out_done_reg  <= out_done_next;
            out_ok_reg    <= out_ok_next;
            out_type_reg  <= out_type_next;
            out_flag_reg  <= flag_next;
            out_width_reg <= width_next;
            out_prec_reg  <= prec_next;
            out_pg_reg    <= prec_given_next;
            out_len_reg   <= length_next;
        end
    end

    // Drive the master side
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {2'b00, out_type_reg, out_len_reg, out_pg_reg, out_prec_reg,
                       out_width_reg, out_flag_reg, out_ok_reg, out_cons_reg};

    // A recognised type always consumes its character and ends the spec
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ok_reg) |-> (out_cons_reg && out_done_reg))
    else $error("valid spec without consume or done");

    // Type code stays zero unless the spec is valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_type_reg == psfp_pkg::TYPE_C))
    else $error("type code set on an invalid result");

    // State is back at its reset values after a spec ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_done_next) |=>
        (phase_reg == psfp_pkg::PH_FLAGS && flag_reg == '0 && !prec_given_reg
         && length_reg == psfp_pkg::LEN_NONE))
    else $error("parse state not cleared after spec end");

    // Back-pressure only while a word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
    else $error("input stalled without a blocked word");

endmodule
